// ----- sv/its_pkg.sv -----
package its_pkg;

    // Character positions within YYYY-MM-DDTHH:MM:SS.
    localparam logic [4:0] IDLE_POS    = 5'd19;
    localparam logic [4:0] LAST_POS    = 5'd18;
    localparam logic [4:0] YEAR_LAST   = 5'd3;
    localparam logic [4:0] MONTH_LAST  = 5'd6;
    localparam logic [4:0] DAY_LAST    = 5'd9;
    localparam logic [4:0] HOUR_LAST   = 5'd12;
    localparam logic [4:0] MINUTE_LAST = 5'd15;
    localparam logic [4:0] SEP_DATE_HI = 5'd4;
    localparam logic [4:0] SEP_DATE_LO = 5'd7;
    localparam logic [4:0] SEP_DATE_T  = 5'd10;
    localparam logic [4:0] SEP_TIME_HI = 5'd13;
    localparam logic [4:0] SEP_TIME_LO = 5'd16;

    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    localparam int CHAR_W  = 8;
    localparam int EPOCH_W = 39;

    // Days in one 400-year Gregorian cycle, and days from 0000-03-01 to 1970-01-01
    // plus one, so that day-of-month 1 lands on the first day.
    localparam logic signed [23:0] ERA_DAYS    = 24'sd146097;
    localparam logic signed [23:0] EPOCH_BIAS  = 24'sd719469;
    localparam logic signed [EPOCH_W-1:0] SEC_PER_DAY = 39'sd86400;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic        err;
    } t_fields;

    // Day of a March-based year on which month mon (0 = January) begins.
    function automatic logic [8:0] month_doy(input logic [3:0] mon);
        logic [8:0] doy;
        case (mon)
            4'd0:    doy = 9'd306;
            4'd1:    doy = 9'd337;
            4'd2:    doy = 9'd0;
            4'd3:    doy = 9'd31;
            4'd4:    doy = 9'd61;
            4'd5:    doy = 9'd92;
            4'd6:    doy = 9'd122;
            4'd7:    doy = 9'd153;
            4'd8:    doy = 9'd184;
            4'd9:    doy = 9'd214;
            4'd10:   doy = 9'd245;
            4'd11:   doy = 9'd275;
            default: doy = 9'd0;
        endcase
        return doy;
    endfunction

endpackage

// ----- sv/iso_timestamp_to_epoch.sv -----
// Converts a timestamp of the fixed form YYYY-MM-DDTHH:MM:SS, streamed in one character
// per transfer, into signed seconds since 1970-01-01T00:00:00 UTC in the proleptic
// Gregorian calendar. Set tuser on the transfer that carries the first year digit; the
// block then counts positions itself, ignores whatever sits in the five separator places,
// and after the nineteenth character issues exactly one result transfer. Characters that
// arrive while no timestamp is open are dropped, and a new start flag abandons any
// timestamp in progress. A month outside 1 to 12 rolls into the year, while day, hour,
// minute and second simply add, so day zero is the last day of the previous month and a
// second of 60 or more runs into the next minute. If any digit position held something
// other than 0 to 9, the result carries zero seconds with the bad-digit flag set. One
// character is accepted in every cycle while back-pressure does not hold it; the
// conversion is a seven-stage pipeline with an elastic ready chain, and a
// back-pressured result only holds up input once that pipeline has filled.
module iso_timestamp_to_epoch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic [0:0]  s_axis_tuser,   // [0] first_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
    output logic [0:0]  m_axis_tuser    // [0] bad_digit
);

    logic                               w_accept;
    logic                               w_done;
    its_pkg::t_fields                   w_fields;
    logic signed [its_pkg::EPOCH_W-1:0] w_epoch;
    logic                               w_bad;

    // A character transfer completes only when the conversion pipeline can take a
    // finished timestamp, so a final character is never lost.
    assign w_accept = s_axis_tvalid && s_axis_tready;

    its_field_gather u_gather (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_char   (s_axis_tdata),
        .i_first  (s_axis_tuser[0]),
        .o_done   (w_done),
        .o_fields (w_fields)
    );

    its_epoch_calc u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_done),
        .o_ready  (s_axis_tready),
        .i_fields (w_fields),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_epoch  (w_epoch),
        .o_bad    (w_bad)
    );

    assign m_axis_tdata = {1'b0, w_epoch};
    assign m_axis_tuser = w_bad;

    // A flagged result always carries zero seconds.
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 40'd0)
        else $error("bad-digit result with non-zero seconds");

    // The start character opens a timestamp and can never close one.
    a_start_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && s_axis_tuser[0] |-> !w_done)
        else $error("start character completed a timestamp");

    // No result is pending straight after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

// ----- sv/its_field_gather.sv -----
module its_field_gather (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [its_pkg::CHAR_W-1:0]    i_char,
    input  logic                          i_first,
    output logic                          o_done,
    output its_pkg::t_fields              o_fields
);

    logic [4:0]       r_pos;
    its_pkg::t_fields r_acc;
    logic [4:0]       n_pos;
    its_pkg::t_fields n_acc;

    logic [4:0]       w_pos;
    its_pkg::t_fields w_base;
    logic             w_active;
    logic             w_is_digit;
    logic             w_is_sep;
    logic [3:0]       w_digit;

    always_comb begin
        // A start flag drops whatever was in progress.
        w_base   = i_first ? '0 : r_acc;
        w_pos    = i_first ? '0 : r_pos;
        w_active = (w_pos < its_pkg::IDLE_POS);

        w_is_digit = (i_char >= its_pkg::DIGIT_ZERO) && (i_char <= its_pkg::DIGIT_NINE);
        w_digit    = w_is_digit ? 4'(i_char - its_pkg::DIGIT_ZERO) : 4'd0;
        w_is_sep   = (w_pos == its_pkg::SEP_DATE_HI) || (w_pos == its_pkg::SEP_DATE_LO) ||
                     (w_pos == its_pkg::SEP_DATE_T)  || (w_pos == its_pkg::SEP_TIME_HI) ||
                     (w_pos == its_pkg::SEP_TIME_LO);

        n_acc = w_base;
        n_pos = w_pos;
        if (w_active) begin
            n_pos = 5'(w_pos + 5'd1);
            if (!w_is_sep) begin
                if (!w_is_digit) begin
                    n_acc.err = 1'b1;
                end
                if (w_pos <= its_pkg::YEAR_LAST) begin
                    n_acc.year = 14'(w_base.year * 14'd10 + 14'(w_digit));
                end else if (w_pos <= its_pkg::MONTH_LAST) begin
                    n_acc.month = 7'(w_base.month * 7'd10 + 7'(w_digit));
                end else if (w_pos <= its_pkg::DAY_LAST) begin
                    n_acc.day = 7'(w_base.day * 7'd10 + 7'(w_digit));
                end else if (w_pos <= its_pkg::HOUR_LAST) begin
                    n_acc.hour = 7'(w_base.hour * 7'd10 + 7'(w_digit));
                end else if (w_pos <= its_pkg::MINUTE_LAST) begin
                    n_acc.minute = 7'(w_base.minute * 7'd10 + 7'(w_digit));
                end else begin
                    n_acc.second = 7'(w_base.second * 7'd10 + 7'(w_digit));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= its_pkg::IDLE_POS;
            r_acc <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_acc <= n_acc;
        end
    end

    assign o_done   = i_accept && (w_pos == its_pkg::LAST_POS);
    assign o_fields = n_acc;

endmodule

// ----- sv/its_epoch_calc.sv -----
module its_epoch_calc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  its_pkg::t_fields                  i_fields,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [its_pkg::EPOCH_W-1:0] o_epoch,
    output logic                              o_bad
);

    typedef struct packed {
        logic        err;
        logic [6:0]  day;
        logic [18:0] hms;
    } t_carry;

    logic [6:0] r_v;
    logic [6:0] w_rdy;

    // Stage 1: gathered fields.
    its_pkg::t_fields r_s1;
    // Stage 2: year shifted to a March-based year, day of year.
    logic signed [15:0] r_s2_yadj;
    logic [8:0]         r_s2_doy;
    t_carry             r_s2_c;
    // Stage 3: year offset by one era, era estimate.
    logic [13:0]        r_s3_yp;
    logic [4:0]         r_s3_q400;
    logic [8:0]         r_s3_doy;
    t_carry             r_s3_c;
    // Stage 4: year of era.
    logic [8:0]         r_s4_yoe;
    logic [6:0]         r_s4_c4;
    logic [1:0]         r_s4_c100;
    logic signed [5:0]  r_s4_era;
    logic [8:0]         r_s4_doy;
    t_carry             r_s4_c;
    // Stage 5: day of era and era start.
    logic [17:0]        r_s5_doe;
    logic signed [23:0] r_s5_eradays;
    t_carry             r_s5_c;
    // Stage 6: days since the epoch.
    logic signed [23:0] r_s6_days;
    t_carry             r_s6_c;
    // Stage 7: result.
    logic signed [its_pkg::EPOCH_W-1:0] r_s7_epoch;
    logic                               r_s7_bad;

    logic [6:0]         w_mm;
    logic [3:0]         w_q_u;
    logic signed [4:0]  w_q;
    logic [3:0]         w_mon;
    logic               w_jan_feb;
    logic signed [15:0] n_s2_yadj;
    t_carry             n_s2_c;
    logic [13:0]        n_s3_yp;
    logic [4:0]         n_s3_q400;
    logic [8:0]         n_s4_yoe;
    logic [6:0]         n_s4_c4;
    logic [1:0]         n_s4_c100;
    logic [17:0]        n_s5_doe;
    logic signed [23:0] n_s5_eradays;
    logic signed [23:0] n_s6_days;
    logic signed [its_pkg::EPOCH_W-1:0] n_s7_epoch;

    always_comb begin
        w_rdy[6] = !r_v[6] || i_ready;
        for (int k = 5; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        // Month normalisation: floor((month - 1) / 12) and its remainder.
        w_mm  = 7'(r_s1.month - 7'd1);
        w_q_u = 4'((11'(w_mm[6:2]) * 11'd43) >> 7);
        if (r_s1.month == 7'd0) begin
            w_q   = -5'sd1;
            w_mon = 4'd11;
        end else begin
            w_q   = $signed({1'b0, w_q_u});
            w_mon = 4'(w_mm - 7'(w_q_u) * 7'd12);
        end
        w_jan_feb = (w_mon < 4'd2);
        n_s2_yadj = $signed({2'b00, r_s1.year}) + 16'(w_q) - $signed({15'b0, w_jan_feb});
        n_s2_c.err = r_s1.err;
        n_s2_c.day = r_s1.day;
        n_s2_c.hms = 19'(19'(r_s1.hour) * 19'd3600 + 19'(r_s1.minute) * 19'd60
                     + 19'(r_s1.second));

        // Year plus one era so that the floor division stays positive.
        n_s3_yp   = 14'(r_s2_yadj + 16'sd400);
        n_s3_q400 = 5'((15'(n_s3_yp[13:4]) * 15'd41) >> 10);

        n_s4_yoe  = 9'(r_s3_yp - 14'(r_s3_q400) * 14'd400);
        n_s4_c4   = n_s4_yoe[8:2];
        n_s4_c100 = 2'((12'(n_s4_c4) * 12'd41) >> 10);

        n_s5_doe     = 18'(18'(r_s4_yoe) * 18'd365 + 18'(r_s4_c4) - 18'(r_s4_c100)
                       + 18'(r_s4_doy));
        n_s5_eradays = 24'(r_s4_era) * its_pkg::ERA_DAYS;

        n_s6_days = r_s5_eradays + $signed({6'b0, r_s5_doe}) - its_pkg::EPOCH_BIAS
                    + $signed({17'b0, r_s5_c.day});

        n_s7_epoch = 39'(r_s6_days) * its_pkg::SEC_PER_DAY + $signed({20'b0, r_s6_c.hms});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < 7; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1 <= i_fields;
        end
        if (w_rdy[1]) begin
            r_s2_yadj <= n_s2_yadj;
            r_s2_doy  <= its_pkg::month_doy(w_mon);
            r_s2_c    <= n_s2_c;
        end
        if (w_rdy[2]) begin
            r_s3_yp   <= n_s3_yp;
            r_s3_q400 <= n_s3_q400;
            r_s3_doy  <= r_s2_doy;
            r_s3_c    <= r_s2_c;
        end
        if (w_rdy[3]) begin
            r_s4_yoe  <= n_s4_yoe;
            r_s4_c4   <= n_s4_c4;
            r_s4_c100 <= n_s4_c100;
            r_s4_era  <= $signed({1'b0, r_s3_q400}) - 6'sd1;
            r_s4_doy  <= r_s3_doy;
            r_s4_c    <= r_s3_c;
        end
        if (w_rdy[4]) begin
            r_s5_doe     <= n_s5_doe;
            r_s5_eradays <= n_s5_eradays;
            r_s5_c       <= r_s4_c;
        end
        if (w_rdy[5]) begin
            r_s6_days <= n_s6_days;
            r_s6_c    <= r_s5_c;
        end
        if (w_rdy[6]) begin
            r_s7_epoch <= r_s6_c.err ? '0 : n_s7_epoch;
            r_s7_bad   <= r_s6_c.err;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[6];
    assign o_epoch = r_s7_epoch;
    assign o_bad   = r_s7_bad;

endmodule

// ----- tb/iso_timestamp_to_epoch_tb.sv -----
`timescale 1ns / 1ps

// One conversion result as it should leave the block.
typedef struct packed {
    logic [its_pkg::EPOCH_W-1:0] epoch;
    logic                        bad;
} t_epoch_result;

// Scoreboard: follows the character stream, works out the seconds value for every
// completed timestamp and compares it with what the block returns.
class t_epoch_scoreboard;
    t_epoch_result      expected_epochs[$];
    int                 errors;
    int                 checked;

    logic [4:0]         pos;
    logic [13:0]        year_val;
    logic [6:0]         month_val;
    logic [6:0]         day_val;
    logic [6:0]         hour_val;
    logic [6:0]         min_val;
    logic [6:0]         sec_val;
    logic               saw_bad;

    function new();
        errors  = 0;
        checked = 0;
        clear_fields();
        pos = its_pkg::IDLE_POS;
    endfunction

    function void clear_fields();
        year_val  = '0;
        month_val = '0;
        day_val   = '0;
        hour_val  = '0;
        min_val   = '0;
        sec_val   = '0;
        saw_bad   = 1'b0;
    endfunction

    function int pending();
        return expected_epochs.size();
    endfunction

    static function longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q -= 1;
        return q;
    endfunction

    // Days from 1970-01-01 to the first day of month m (1..12) of year y,
    // counted with a March-based year in 400-year eras.
    static function longint days_to_month_first(longint y, longint m);
        longint era, yoe, doy, doe;
        if (m <= 2)
            y -= 1;
        era = floor_quot(y, 400);
        yoe = y - era * 400;
        doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function logic [its_pkg::EPOCH_W-1:0] epoch_of_fields();
        longint mm, y, mon, days, secs;
        mm   = longint'(month_val) - 1;
        y    = longint'(year_val) + floor_quot(mm, 12);
        mon  = mm - floor_quot(mm, 12) * 12;
        days = days_to_month_first(y, mon + 1) + longint'(day_val) - 1;
        secs = days * 86400 + longint'(hour_val) * 3600 + longint'(min_val) * 60
             + longint'(sec_val);
        return secs[its_pkg::EPOCH_W-1:0];
    endfunction

    // Called for every accepted input transfer.
    function void take_char(logic [7:0] c, logic start);
        logic          is_digit;
        logic [3:0]    d;
        logic [4:0]    at;
        t_epoch_result res;
        if (start) begin
            clear_fields();
            pos = '0;
        end
        if (pos >= its_pkg::IDLE_POS)
            return;
        at       = pos;
        is_digit = (c >= its_pkg::DIGIT_ZERO) && (c <= its_pkg::DIGIT_NINE);
        d        = is_digit ? 4'(c - its_pkg::DIGIT_ZERO) : 4'd0;
        if (at != its_pkg::SEP_DATE_HI && at != its_pkg::SEP_DATE_LO &&
            at != its_pkg::SEP_DATE_T && at != its_pkg::SEP_TIME_HI &&
            at != its_pkg::SEP_TIME_LO) begin
            if (!is_digit)
                saw_bad = 1'b1;
            if (at <= its_pkg::YEAR_LAST)
                year_val = year_val * 14'd10 + 14'(d);
            else if (at <= its_pkg::MONTH_LAST)
                month_val = month_val * 7'd10 + 7'(d);
            else if (at <= its_pkg::DAY_LAST)
                day_val = day_val * 7'd10 + 7'(d);
            else if (at <= its_pkg::HOUR_LAST)
                hour_val = hour_val * 7'd10 + 7'(d);
            else if (at <= its_pkg::MINUTE_LAST)
                min_val = min_val * 7'd10 + 7'(d);
            else
                sec_val = sec_val * 7'd10 + 7'(d);
        end
        pos = at + 5'd1;
        if (at == its_pkg::LAST_POS) begin
            res.bad   = saw_bad;
            res.epoch = saw_bad ? '0 : epoch_of_fields();
            expected_epochs = {expected_epochs, res};
        end
    endfunction

    task report(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Called for every accepted output transfer.
    task check_epoch(logic [its_pkg::EPOCH_W:0] data, logic [0:0] user);
        t_epoch_result want;
        checked++;
        if (expected_epochs.size() == 0) begin
            report($sformatf("result %0d with nothing expected",
                             $signed(data[its_pkg::EPOCH_W-1:0])));
            return;
        end
        want = expected_epochs.pop_front();
        if (data[its_pkg::EPOCH_W-1:0] !== want.epoch)
            report($sformatf("epoch_seconds %0d, expected %0d",
                             $signed(data[its_pkg::EPOCH_W-1:0]), $signed(want.epoch)));
        if (data[its_pkg::EPOCH_W] !== 1'b0)
            report("tdata padding bit is not zero");
        if (user[0] !== want.bad)
            report($sformatf("bad_digit %0b, expected %0b", user[0], want.bad));
    endtask
endclass

module iso_timestamp_to_epoch_tb;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata;   // [7:0] char_in
    logic [0:0]                s_axis_tuser;   // [0] first_char
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [its_pkg::EPOCH_W:0] m_axis_tdata;   // [38:0] epoch_seconds, [39] zero
    logic [0:0]                m_axis_tuser;   // [0] bad_digit

    t_epoch_scoreboard sb = new();

    // Accepted input transfers, and characters sent as part of timestamps.
    int chars_sent;
    int stamp_chars;

    iso_timestamp_to_epoch dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Both handshakes are sampled at the rising edge, before any of this edge's
    // nonblocking updates land, so the order of processes within the step does not
    // matter. The receiver stalls at random with a chance of 38 percent, except for a
    // stretch of results during which it is always ready.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_char(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_epoch(m_axis_tdata, m_axis_tuser);
        end
        m_axis_tready <= (sb.checked >= 20 && sb.checked < 40) || ($urandom_range(0, 99) >= 38);
    end

    function automatic logic [7:0] ascii_digit(int n);
        return its_pkg::DIGIT_ZERO + 8'(n % 10);
    endfunction

    // Presents one character and holds it until the block takes it. Idle cycles are
    // inserted in front of it at random, apart from a long run of transfers in the
    // middle of the test which go back to back.
    task automatic send_char(input logic [7:0] c, input logic start);
        while (!(chars_sent >= 600 && chars_sent < 850) && $urandom_range(0, 99) < 38) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            @(posedge i_clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= c;
        s_axis_tuser[0] <= start;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        chars_sent++;
    endtask

    // Sends the first len characters of YYYY-MM-DDTHH:MM:SS built from the given
    // values. Separators may be replaced by arbitrary bytes, and the character at
    // bad_at (if not negative) by a non-digit, often one adjacent to the digit codes.
    task automatic send_stamp(input int yr, input int mo, input int dy, input int hr,
                              input int mi, input int se, input int bad_at,
                              input int len, input bit wild_seps);
        logic [7:0] txt [19];
        logic [7:0] junk;
        int         pick;
        txt[0]  = ascii_digit(yr / 1000);
        txt[1]  = ascii_digit(yr / 100);
        txt[2]  = ascii_digit(yr / 10);
        txt[3]  = ascii_digit(yr);
        txt[4]  = "-";
        txt[5]  = ascii_digit(mo / 10);
        txt[6]  = ascii_digit(mo);
        txt[7]  = "-";
        txt[8]  = ascii_digit(dy / 10);
        txt[9]  = ascii_digit(dy);
        txt[10] = "T";
        txt[11] = ascii_digit(hr / 10);
        txt[12] = ascii_digit(hr);
        txt[13] = ":";
        txt[14] = ascii_digit(mi / 10);
        txt[15] = ascii_digit(mi);
        txt[16] = ":";
        txt[17] = ascii_digit(se / 10);
        txt[18] = ascii_digit(se);
        if (wild_seps) begin
            txt[its_pkg::SEP_DATE_HI] = 8'($urandom_range(0, 255));
            txt[its_pkg::SEP_DATE_LO] = 8'($urandom_range(0, 255));
            txt[its_pkg::SEP_DATE_T]  = 8'($urandom_range(0, 255));
            txt[its_pkg::SEP_TIME_HI] = 8'($urandom_range(0, 255));
            txt[its_pkg::SEP_TIME_LO] = 8'($urandom_range(0, 255));
        end
        if (bad_at >= 0) begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                junk = its_pkg::DIGIT_ZERO - 8'd1;
            else if (pick == 1)
                junk = its_pkg::DIGIT_NINE + 8'd1;
            else begin
                do
                    junk = 8'($urandom_range(0, 255));
                while (junk >= its_pkg::DIGIT_ZERO && junk <= its_pkg::DIGIT_NINE);
            end
            txt[bad_at] = junk;
        end
        for (int i = 0; i < len; i++)
            send_char(txt[i], i == 0);
        stamp_chars += len;
    endtask

    task automatic send_ignored(input int count);
        repeat (count)
            send_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial begin
        int r, yr;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        m_axis_tready   = 1'b0;
        chars_sent      = 0;
        stamp_chars     = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Characters before any start flag must be dropped.
        send_ignored(3);
        send_stamp(1970, 1, 1, 0, 0, 0, -1, 19, 1'b0);
        send_stamp(0, 1, 1, 0, 0, 0, -1, 19, 1'b0);
        // Every digit at nine: month 99 rolls several years forward.
        send_stamp(9999, 99, 99, 99, 99, 99, -1, 19, 1'b0);
        // Month zero means December of the year before, day zero the day before the 1st.
        send_stamp(0, 0, 0, 0, 0, 0, -1, 19, 1'b0);
        send_stamp(2000, 2, 29, 23, 59, 59, -1, 19, 1'b0);
        // A leap second runs into the next minute.
        send_stamp(1969, 12, 31, 23, 59, 60, -1, 19, 1'b0);
        send_stamp(2024, 5, 17, 8, 30, 0, -1, 19, 1'b1);
        // Non-digits in the first and the last digit positions.
        send_stamp(2024, 5, 17, 8, 30, 0, 0, 19, 1'b0);
        send_stamp(2024, 5, 17, 8, 30, 0, 18, 19, 1'b0);
        // A start flag in the middle of a timestamp abandons it.
        send_stamp(1999, 12, 31, 23, 59, 59, -1, 10, 1'b0);
        send_stamp(2038, 1, 19, 3, 14, 8, -1, 19, 1'b0);
        // Characters after the seconds are ignored until the next start.
        send_ignored(4);

        // Random part: mostly well-formed timestamps with random content, the rest
        // out-of-range fields, bad digits, abandoned timestamps and line noise.
        while (stamp_chars < 1400) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                yr = ($urandom_range(0, 1) == 1) ? $urandom_range(1900, 2100)
                                                 : $urandom_range(0, 9999);
                send_stamp(yr, $urandom_range(1, 12), $urandom_range(1, 31),
                           $urandom_range(0, 23), $urandom_range(0, 59),
                           $urandom_range(0, 59), -1, 19, $urandom_range(0, 4) == 0);
            end else if (r < 75) begin
                send_stamp($urandom_range(0, 9999), $urandom_range(0, 99),
                           $urandom_range(0, 99), $urandom_range(0, 99),
                           $urandom_range(0, 99), $urandom_range(0, 99),
                           -1, 19, $urandom_range(0, 1));
            end else if (r < 85) begin
                send_stamp($urandom_range(0, 9999), $urandom_range(0, 19),
                           $urandom_range(0, 39), $urandom_range(0, 29),
                           $urandom_range(0, 69), $urandom_range(0, 69),
                           $urandom_range(0, 18), 19, $urandom_range(0, 1));
            end else if (r < 93) begin
                send_stamp($urandom_range(0, 9999), $urandom_range(1, 12),
                           $urandom_range(1, 28), $urandom_range(0, 23),
                           $urandom_range(0, 59), $urandom_range(0, 59),
                           -1, $urandom_range(1, 18), 1'b0);
            end else begin
                // Noise with an occasional start flag, which opens a timestamp that
                // the next one will usually abandon.
                repeat ($urandom_range(1, 6))
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
            if ($urandom_range(0, 99) < 15)
                send_ignored($urandom_range(1, 3));
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every outstanding result, then a little past the
        // pipeline depth to catch anything unexpected.
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("** iso_timestamp_to_epoch: PASSED **");
        else
            $display("** iso_timestamp_to_epoch: FAILED **");
        $finish;
    end

    // Watchdog for a block that stops handshaking.
    initial begin
        #2000000;
        $display("** iso_timestamp_to_epoch: FAILED **");
        $finish;
    end

endmodule
